// File: src/fcd_pkg.sv
// Shared types, constants and the per-pixel change test for the frame change detector.
package fcd_pkg;

  // Frame geometry: one store entry holds one luma pair.
  localparam int unsigned FRAME_PAIRS = 153600;
  localparam int unsigned ADDR_W      = (FRAME_PAIRS > 1) ? $clog2(FRAME_PAIRS) : 1;

  // Luma lanes per item (even and odd pixel of a macropixel).
  localparam int unsigned LANES  = 2;
  localparam int unsigned LUMA_W = 8;
  localparam int unsigned PAIR_W = LANES * LUMA_W;
  localparam int unsigned NUM_W  = $clog2(LANES + 1);

  // Changed-pixel counter, saturating.
  localparam int unsigned COUNT_W = 19;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = COUNT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOLERANCE  = 3'd0,
    REG_LEVEL_MAX  = 3'd1,
    REG_LEVEL_MIN  = 3'd2,
    REG_COUNT_LOW  = 3'd3,
    REG_COUNT_HIGH = 3'd4
  } cfg_idx_e;

  localparam logic [LUMA_W-1:0]  TOLERANCE_RST  = 8'd10;
  localparam logic [LUMA_W-1:0]  LEVEL_MAX_RST  = 8'd255;
  localparam logic [LUMA_W-1:0]  LEVEL_MIN_RST  = 8'd0;
  localparam logic [COUNT_W-1:0] COUNT_LOW_RST  = 19'd0;
  localparam logic [COUNT_W-1:0] COUNT_HIGH_RST = 19'd307200;

  typedef struct packed {
    logic [LUMA_W-1:0]  tolerance;
    logic [LUMA_W-1:0]  level_max;
    logic [LUMA_W-1:0]  level_min;
    logic [COUNT_W-1:0] count_low;
    logic [COUNT_W-1:0] count_high;
  } cfg_t;

  // Per-stage control carried alongside the payload.
  typedef struct packed {
    logic valid;
    logic frame_end;
    logic have_prev;
  } stage_t;

  // Change test on one pixel. All terms are kept non-negative:
  //   prev >= max - tol  <=>  prev + tol >= max
  //   cur  >= prev - tol <=>  cur + tol >= prev
  function automatic logic pixel_changed(
    input logic [LUMA_W-1:0] prev,
    input logic [LUMA_W-1:0] cur,
    input logic [LUMA_W-1:0] tol,
    input logic [LUMA_W-1:0] lmax,
    input logic [LUMA_W-1:0] lmin
  );
    logic [LUMA_W:0] prev_up;
    logic [LUMA_W:0] cur_up;
    logic [LUMA_W:0] lmin_up;
    logic            below;
    logic            above;
    logic            chg;
    prev_up = {1'b0, prev} + {1'b0, tol};
    cur_up  = {1'b0, cur} + {1'b0, tol};
    lmin_up = {1'b0, lmin} + {1'b0, tol};
    below   = cur_up < {1'b0, prev};
    above   = {1'b0, cur} > prev_up;
    if (prev_up >= {1'b0, lmax}) begin
      chg = below;          // near the top: only a drop counts
    end else if ({1'b0, prev} <= lmin_up) begin
      chg = above;          // near the bottom: only a rise counts
    end else begin
      chg = below | above;
    end
    return chg;
  endfunction

endpackage

// File: src/fcd_frame_store.sv
// Frame store: previous-frame luma pairs, one write and one registered read per enabled cycle.
module fcd_frame_store (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [fcd_pkg::ADDR_W-1:0]      addr_i,
  input  logic [fcd_pkg::PAIR_W-1:0]      wdata_i,
  output logic [fcd_pkg::PAIR_W-1:0]      rdata_o
);

  logic [fcd_pkg::PAIR_W-1:0] mem [fcd_pkg::FRAME_PAIRS];
  logic [fcd_pkg::PAIR_W-1:0] rdata_q;

  // Read returns the old entry; the new pair replaces it on the same edge.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q      <= mem[addr_i];
      mem[addr_i]  <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/fcd_lane.sv
// One luma lane: compares a pixel with its stored predecessor and registers the flag.
module fcd_lane (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [fcd_pkg::LUMA_W-1:0]  prev_i,
  input  logic [fcd_pkg::LUMA_W-1:0]  cur_i,
  input  fcd_pkg::cfg_t               cfg_i,
  output logic                        changed_o
);

  logic changed_d;
  logic changed_q;

  assign changed_d = fcd_pkg::pixel_changed(prev_i, cur_i, cfg_i.tolerance,
                                            cfg_i.level_max, cfg_i.level_min);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      changed_q <= changed_d;
    end
  end

  assign changed_o = changed_q;

endmodule

// File: src/fcd_merge.sv
// Merge stage: sums the lane flags into the frame counter and builds the frame result.
module fcd_merge (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fcd_pkg::stage_t               stage_i,
  input  logic [fcd_pkg::LANES-1:0]     changed_i,
  input  fcd_pkg::cfg_t                 cfg_i,
  output logic                          advance_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [fcd_pkg::COUNT_W-1:0]   changed_pixels_o,
  output logic                          change_found_o,
  output logic                          compared_o
);

  logic [fcd_pkg::NUM_W-1:0]   num;
  logic [fcd_pkg::COUNT_W:0]   sum;
  logic [fcd_pkg::COUNT_W-1:0] count_new;
  logic [fcd_pkg::COUNT_W-1:0] count_d;
  logic [fcd_pkg::COUNT_W-1:0] count_q;
  logic                        out_free;
  logic                        out_valid_d;
  logic                        out_valid_q;
  logic [fcd_pkg::COUNT_W-1:0] res_count_q;
  logic                        res_found_q;
  logic                        res_cmp_q;

  // Number of changed pixels in this item
  always_comb begin
    num = '0;
    for (int i = 0; i < fcd_pkg::LANES; i++) begin
      num = num + fcd_pkg::NUM_W'(changed_i[i]);
    end
  end

  // Saturating add; first frame counts nothing
  assign sum       = {1'b0, count_q} + (fcd_pkg::COUNT_W + 1)'(stage_i.have_prev ? num : '0);
  assign count_new = sum[fcd_pkg::COUNT_W] ? '1 : sum[fcd_pkg::COUNT_W-1:0];

  // Items without a result never wait; a frame end waits for a free output slot
  assign out_free  = !out_valid_q || !out_stall_i;
  assign advance_o = stage_i.valid && (!stage_i.frame_end || out_free);

  always_comb begin
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (advance_o) begin
      count_d = stage_i.frame_end ? '0 : count_new;
      if (stage_i.frame_end) begin
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (advance_o && stage_i.frame_end) begin
      res_count_q <= count_new;
      res_found_q <= stage_i.have_prev && (count_new >= cfg_i.count_low)
                     && (count_new <= cfg_i.count_high);
      res_cmp_q   <= stage_i.have_prev;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign changed_pixels_o = res_count_q;
  assign change_found_o   = res_found_q;
  assign compared_o       = res_cmp_q;

endmodule

// File: src/frame_change_detector_unit.sv
// Frame change detector top level: config registers, frame store, luma lanes and merge.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------------------
//   in      | input     | in_valid_i/in_stall_o  | luma_even_i, luma_odd_i, frame_end_i
//   out     | output    | out_valid_o/out_stall_i| changed_pixels_o, change_found_o,
//           |           |                        | compared_o
//   cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// One item per cycle sustained while in_stall_o is low, set by the single frame store read/write port.
// An item reaches the result through the store read, the lane compare and the merge, each registered.
// Reset clears the address, counter and first-frame flag and loads the config defaults; the frame store
// is not cleared, the first frame fills it.
// in_stall_o rises only while a frame result sits stalled at the output and a
// frame end is queued behind it.
module frame_change_detector_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [fcd_pkg::LUMA_W-1:0]     luma_even_i,
  input  logic [fcd_pkg::LUMA_W-1:0]     luma_odd_i,
  input  logic                           frame_end_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [fcd_pkg::COUNT_W-1:0]    changed_pixels_o,
  output logic                           change_found_o,
  output logic                           compared_o,
  input  logic                           cfg_we_i,
  input  logic [fcd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fcd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  fcd_pkg::cfg_t                  cfg_d, cfg_q;
  logic                           accept;
  logic [fcd_pkg::ADDR_W-1:0]     addr_d, addr_q;
  logic                           have_prev_d, have_prev_q;
  logic [fcd_pkg::PAIR_W-1:0]     stored_pair;
  fcd_pkg::stage_t                s1_d, s1_q, s2_d, s2_q;
  logic [fcd_pkg::PAIR_W-1:0]     s1_pair_q;
  logic                           s1_adv;
  logic                           s2_adv;
  logic [fcd_pkg::LANES-1:0]      lane_changed;

  // Config register decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (fcd_pkg::cfg_idx_e'(cfg_idx_i))
        fcd_pkg::REG_TOLERANCE:  cfg_d.tolerance  = cfg_data_i[fcd_pkg::LUMA_W-1:0];
        fcd_pkg::REG_LEVEL_MAX:  cfg_d.level_max  = cfg_data_i[fcd_pkg::LUMA_W-1:0];
        fcd_pkg::REG_LEVEL_MIN:  cfg_d.level_min  = cfg_data_i[fcd_pkg::LUMA_W-1:0];
        fcd_pkg::REG_COUNT_LOW:  cfg_d.count_low  = cfg_data_i[fcd_pkg::COUNT_W-1:0];
        fcd_pkg::REG_COUNT_HIGH: cfg_d.count_high = cfg_data_i[fcd_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  assign s1_adv     = s1_q.valid && (!s2_q.valid || s2_adv);
  assign in_stall_o = s1_q.valid && s2_q.valid && !s2_adv;
  assign accept     = in_valid_i && !in_stall_o;

  // Pair address: back to zero at frame end, holds on the last entry of a long frame
  always_comb begin
    addr_d      = addr_q;
    have_prev_d = have_prev_q;
    if (accept) begin
      if (frame_end_i) begin
        addr_d      = '0;
        have_prev_d = 1'b1;
      end else if (addr_q != fcd_pkg::ADDR_W'(fcd_pkg::FRAME_PAIRS - 1)) begin
        addr_d = addr_q + 1'b1;
      end
    end
  end

  // Stage valid/control
  always_comb begin
    s1_d = s1_q;
    if (accept) begin
      s1_d.valid     = 1'b1;
      s1_d.frame_end = frame_end_i;
      s1_d.have_prev = have_prev_q;
    end else if (s1_adv) begin
      s1_d.valid = 1'b0;
    end
    s2_d = s2_q;
    if (s1_adv) begin
      s2_d = s1_q;
    end else if (s2_adv) begin
      s2_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tolerance  <= fcd_pkg::TOLERANCE_RST;
      cfg_q.level_max  <= fcd_pkg::LEVEL_MAX_RST;
      cfg_q.level_min  <= fcd_pkg::LEVEL_MIN_RST;
      cfg_q.count_low  <= fcd_pkg::COUNT_LOW_RST;
      cfg_q.count_high <= fcd_pkg::COUNT_HIGH_RST;
      addr_q           <= '0;
      have_prev_q      <= 1'b0;
      s1_q             <= '0;
      s2_q             <= '0;
    end else begin
      cfg_q       <= cfg_d;
      addr_q      <= addr_d;
      have_prev_q <= have_prev_d;
      s1_q        <= s1_d;
      s2_q        <= s2_d;
    end
  end

  // Current pair travels with the store read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pair_q <= {luma_odd_i, luma_even_i};
    end
  end

  fcd_frame_store u_store (
    .clk_i   (clk_i),
    .en_i    (accept),
    .addr_i  (addr_q),
    .wdata_i ({luma_odd_i, luma_even_i}),
    .rdata_o (stored_pair)
  );

  // One lane per luma sample; even pixel in the low byte
  for (genvar g = 0; g < fcd_pkg::LANES; g++) begin : g_lane
    fcd_lane u_lane (
      .clk_i     (clk_i),
      .en_i      (s1_adv),
      .prev_i    (stored_pair[g*fcd_pkg::LUMA_W +: fcd_pkg::LUMA_W]),
      .cur_i     (s1_pair_q[g*fcd_pkg::LUMA_W +: fcd_pkg::LUMA_W]),
      .cfg_i     (cfg_q),
      .changed_o (lane_changed[g])
    );
  end

  fcd_merge u_merge (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .stage_i          (s2_q),
    .changed_i        (lane_changed),
    .cfg_i            (cfg_q),
    .advance_o        (s2_adv),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .changed_pixels_o (changed_pixels_o),
    .change_found_o   (change_found_o),
    .compared_o       (compared_o)
  );

endmodule

// File: src/fcd_checker.sv
// Port-level checks on the frame change detector, bound to the top level.
module fcd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic [fcd_pkg::LUMA_W-1:0]     luma_even_i,
  input logic [fcd_pkg::LUMA_W-1:0]     luma_odd_i,
  input logic                           frame_end_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [fcd_pkg::COUNT_W-1:0]    changed_pixels_o,
  input logic                           change_found_o,
  input logic                           compared_o
);

  // A change can only be reported for a frame that had a predecessor
  a_found_needs_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && change_found_o |-> compared_o)
    else $error("change reported without a previous frame");

  // The first frame counts nothing
  a_first_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !compared_o |-> changed_pixels_o == '0)
    else $error("first frame result carries a nonzero count");

  // Input backs up only behind a blocked result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output is free");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(changed_pixels_o)
      && $stable(change_found_o) && $stable(compared_o))
    else $error("stalled result changed");

  // A stalled input item holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(luma_even_i)
      && $stable(luma_odd_i) && $stable(frame_end_i))
    else $error("stalled input item changed");

endmodule

bind frame_change_detector_unit fcd_checker u_fcd_checker (.*);
